// ===== src/expiring_slot_pool_allocator_assert.svh =====
// Assertion macros used by the allocator datapath module.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef EXPIRING_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define EXPIRING_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/espa_pkg.sv =====
`timescale 1ns / 1ps

package espa_pkg;

  // Field widths fixed by the interface.
  localparam int LIMIT_W    = 9;
  localparam int LIFE_W     = 16;
  localparam int STEP_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int TIME_W     = 32;
  localparam int OUT_IDX_W  = 8;
  localparam int LIVE_W     = 9;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIFETIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFETIME = 2'd2;

  // Command codes of an input word.
  localparam logic CMD_SPAWN   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 9'd256;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SPAWN_WR,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic latch;
    logic spawn_rd;
    logic spawn_wr;
    logic advance;
    logic scan_start;
    logic scan_rd;
    logic emit;
    logic emit_acc;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_spawn;
    logic spawn_ok;
    logic scan_ok;
    logic scan_last;
  } dp_status_t;

endpackage

// ===== src/espa_ctrl.sv =====
`timescale 1ns / 1ps

module espa_ctrl import espa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  // State register; reset enters the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_spawn) begin
          if (status.spawn_ok) begin
            cmd.spawn_rd = 1'b1;
            state_nxt    = ST_SPAWN_WR;
          end else begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          if (status.scan_ok) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SPAWN_WR: begin
        cmd.spawn_wr = 1'b1;
        cmd.emit     = 1'b1;
        cmd.emit_acc = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // The last slot read is tallied in this cycle.
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/espa_dp.sv =====
`timescale 1ns / 1ps

module espa_dp import espa_pkg::*; #(
  parameter int POOL_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic                  in_command,
  input  logic [STEP_W-1:0]     in_time_step,
  input  logic [FRAC_W-1:0]     in_random_fraction,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic [OUT_IDX_W-1:0]  out_slot_index,
  output logic [LIVE_W-1:0]     out_live_count
);

  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int SUM_W = CNT_W + 1;
  localparam int PROD_W = LIFE_W + FRAC_W;
  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);
  localparam logic [CMP_W-1:0] POOL_CMP = CMP_W'(POOL_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

  // Saturating time sum.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // Configuration registers.
  logic [LIMIT_W-1:0] slot_limit_r;
  logic [LIFE_W-1:0]  min_life_r;
  logic [LIFE_W-1:0]  max_life_r;

  // Latched input word.
  logic              cmd_r;
  logic [STEP_W-1:0] step_r;
  logic [FRAC_W-1:0] frac_r;

  // Allocator state.
  logic [TIME_W-1:0] frame_start_r;
  logic [TIME_W-1:0] frame_end_r;
  logic [CNT_W-1:0]  free_head_r;
  logic [CNT_W-1:0]  free_count_r;
  logic [CNT_W-1:0]  free_count_nxt;
  logic [CNT_W-1:0]  live_r;
  logic [CNT_W-1:0]  live_nxt;

  // Sweep address and scan pipeline.
  logic [IDX_W-1:0]  addr_r;
  logic [IDX_W-1:0]  proc_idx_r;
  logic              rd_vld_r;
  logic [TIME_W-1:0] exp_rd_r;
  logic [IDX_W-1:0]  fl_rd_r;

  // Lifetime blend product.
  logic [PROD_W-1:0] prod_r;
  logic              ge_r;

  // Result registers.
  logic                 out_valid_r;
  logic                 out_accepted_r;
  logic [OUT_IDX_W-1:0] out_slot_r;
  logic [LIVE_W-1:0]    out_live_r;

  // Memories.
  logic [TIME_W-1:0] expiry_mem [POOL_SLOTS];
  logic [IDX_W-1:0]  free_mem   [POOL_SLOTS];

  logic [CMP_W-1:0]  limit_cmp;
  logic [CNT_W-1:0]  eff_limit;
  logic              ge;
  logic [LIFE_W-1:0] diff;
  logic [LIFE_W-1:0] delta;
  logic [LIFE_W-1:0] lifetime;
  logic [TIME_W-1:0] exp_new;
  logic              hit_dead;
  logic              hit_live;

  // Effective limit: the configured limit clipped to the pool.
  assign limit_cmp = CMP_W'(slot_limit_r);
  assign eff_limit = (limit_cmp > POOL_CMP) ? POOL_CNT : CNT_W'(limit_cmp);

  // Blend operands from the lifetime range.
  assign ge   = (max_life_r >= min_life_r);
  assign diff = ge ? (max_life_r - min_life_r) : (min_life_r - max_life_r);

  // Expiry of a spawned slot from the registered product.
  assign delta    = prod_r[PROD_W-1:FRAC_W];
  assign lifetime = ge_r ? (min_life_r + delta) : (min_life_r - delta);
  assign exp_new  = sat_add(frame_start_r, TIME_W'(lifetime));

  // Scan verdict on the slot read in the previous cycle.
  assign hit_dead = rd_vld_r && (exp_rd_r <= frame_end_r);
  assign hit_live = rd_vld_r && (exp_rd_r > frame_end_r);

  // Status to the controller.
  assign status.clr_last  = (addr_r == LAST_IDX);
  assign status.is_spawn  = (cmd_r == CMD_SPAWN);
  assign status.spawn_ok  = (live_r < eff_limit) && (free_head_r < free_count_r);
  assign status.scan_ok   = (eff_limit != '0) && (live_r != '0);
  assign status.scan_last = (CNT_W'(addr_r) == (eff_limit - CNT_W'(1)));

  // Next live and free counts.
  always_comb begin
    live_nxt       = live_r;
    free_count_nxt = free_count_r;
    if (cmd.scan_start) begin
      live_nxt       = '0;
      free_count_nxt = '0;
    end else begin
      if (cmd.spawn_wr || hit_live) begin
        live_nxt = live_r + CNT_W'(1);
      end
      if (hit_dead) begin
        free_count_nxt = free_count_r + CNT_W'(1);
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= SLOT_LIMIT_RESET;
      min_life_r   <= '0;
      max_life_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_LIMIT:   slot_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_MIN_LIFETIME: min_life_r   <= cfg_wdata[LIFE_W-1:0];
        CFG_MAX_LIFETIME: max_life_r   <= cfg_wdata[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word capture and blend multiply.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_command;
      step_r <= in_time_step;
      frac_r <= in_random_fraction;
    end
    if (cmd.spawn_rd) begin
      prod_r <= PROD_W'(diff) * PROD_W'(frac_r);
      ge_r   <= ge;
    end
  end

  // Allocator state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= '0;
      frame_end_r   <= '0;
      free_head_r   <= '0;
      free_count_r  <= POOL_CNT;
      live_r        <= '0;
      addr_r        <= '0;
      rd_vld_r      <= 1'b0;
    end else begin
      live_r       <= live_nxt;
      free_count_r <= free_count_nxt;
      rd_vld_r     <= cmd.scan_rd;
      if (cmd.advance) begin
        frame_start_r <= frame_end_r;
        frame_end_r   <= sat_add(frame_end_r, TIME_W'(step_r));
      end
      if (cmd.scan_start) begin
        free_head_r <= '0;
      end else if (cmd.spawn_wr) begin
        free_head_r <= free_head_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        addr_r <= '0;
      end else if (cmd.clear || cmd.scan_rd) begin
        addr_r <= addr_r + IDX_W'(1);
      end
    end
  end

  // Slot index that travels with each scan read.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      proc_idx_r <= addr_r;
    end
  end

  // Expiry memory: cleared after reset, written by spawns, read by the scan.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      expiry_mem[addr_r] <= '0;
    end else if (cmd.spawn_wr) begin
      expiry_mem[fl_rd_r] <= exp_new;
    end
    if (cmd.scan_rd) begin
      exp_rd_r <= expiry_mem[addr_r];
    end
  end

  // Free list memory: identity after reset, rebuilt by the scan.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      free_mem[addr_r] <= addr_r;
    end else if (hit_dead) begin
      free_mem[free_count_r[IDX_W-1:0]] <= proc_idx_r;
    end
    if (cmd.spawn_rd) begin
      fl_rd_r <= free_mem[free_head_r[IDX_W-1:0]];
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_accepted_r <= cmd.emit_acc;
      out_slot_r     <= cmd.emit_acc ? OUT_IDX_W'(fl_rd_r) : '0;
      out_live_r     <= LIVE_W'(live_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_slot_index = out_slot_r;
  assign out_live_count = out_live_r;

`include "expiring_slot_pool_allocator_assert.svh"

  `ESPA_ASSERT_NOW(a_free_count_bound, 1'b1, free_count_r <= POOL_CNT, "free count beyond pool")
  `ESPA_ASSERT_NOW(a_refused_slot_zero, out_valid_r && !out_accepted_r, out_slot_r == '0, "refused word carries a slot")
  `ESPA_ASSERT_NOW(a_scan_tally, cmd.scan_rd, (SUM_W'(live_r) + SUM_W'(free_count_r)) < SUM_W'(eff_limit), "scan tally exceeds limit")
  `ESPA_ASSERT_NEXT(a_spawn_bumps_live, cmd.spawn_wr, live_r == $past(live_r) + CNT_W'(1), "spawn did not count a live slot")

endmodule

// ===== src/expiring_slot_pool_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                                  Handshake
// input     in_command, in_time_step, in_random_fraction           start && !busy
// result    out_accepted, out_slot_index, out_live_count           out_valid, one cycle
// config    cfg_index, cfg_wdata                                   cfg_we
//
// A spawn word passes decode and spawn write before the next acceptance; a refused spawn
// or an advance with no live slot returns from decode to idle; a rescan sweeps expiry
// slots 0 to L - 1, with L the effective slot limit: the scan reads one expiry memory
// entry per cycle. After reset a clearing pass over all POOL_SLOTS entries initializes
// both memories; busy stays high meanwhile, configuration writes are still taken. The
// result word is strobed in the cycle after its item finishes; the receiver cannot stall.

module expiring_slot_pool_allocator import espa_pkg::*; #(
  parameter int POOL_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [STEP_W-1:0]     in_time_step,
  input  logic [FRAC_W-1:0]     in_random_fraction,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic [OUT_IDX_W-1:0]  out_slot_index,
  output logic [LIVE_W-1:0]     out_live_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  espa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Memories, counters and arithmetic.
  espa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_command         (in_command),
    .in_time_step       (in_time_step),
    .in_random_fraction (in_random_fraction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_accepted       (out_accepted),
    .out_slot_index     (out_slot_index),
    .out_live_count     (out_live_count)
  );

endmodule
